// File: rtl/mpwm_pkg.sv
// ----------------------------------------------------------------------------
// mpwm_pkg
// Shared constants, types and helpers for the multichannel PWM register block.
// ----------------------------------------------------------------------------
package mpwm_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int COUNT_BITS   = 12;
  localparam int LEVEL_W      = 16;
  localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  localparam logic [7:0] ADDR_MODE1    = 8'h00;
  localparam logic [7:0] ADDR_MODE2    = 8'h01;
  localparam logic [7:0] ADDR_CH_BASE  = 8'h06;
  localparam logic [7:0] ADDR_ALL_LO   = 8'hFA;
  localparam logic [7:0] ADDR_ALL_HI   = 8'hFD;
  localparam logic [7:0] ADDR_PRESCALE = 8'hFE;

  localparam logic [8:0] CH_BYTES = 9'(4 * NUM_CHANNELS);

  // Byte slots within one channel.
  localparam int SLOT_ON_L  = 0;
  localparam int SLOT_ON_H  = 1;
  localparam int SLOT_OFF_L = 2;
  localparam int SLOT_OFF_H = 3;

  localparam int         FULL_BIT     = 4;
  localparam int         SLEEP_BIT    = 4;
  localparam logic [7:0] PRESCALE_MIN = 8'd3;
  localparam logic [7:0] PRESCALE_RST = 8'd30;
  localparam logic [7:0] MODE1_RST    = 8'h11;
  localparam logic [7:0] MODE2_RST    = 8'h04;
  localparam logic [7:0] OFF_H_RST    = 8'h10;

  typedef logic [7:0] ch_regs_t [4];

  // Level of one channel at the given period count.
  function automatic logic level_of(input logic [7:0] on_l, input logic [7:0] on_h,
                                    input logic [7:0] off_l, input logic [7:0] off_h,
                                    input logic [COUNT_BITS-1:0] count);
    logic [11:0]           on_full;
    logic [11:0]           off_full;
    logic [COUNT_BITS-1:0] on_cnt;
    logic [COUNT_BITS-1:0] off_cnt;
    logic                  lvl;
    on_full  = {on_h[3:0], on_l};
    off_full = {off_h[3:0], off_l};
    on_cnt   = on_full[COUNT_BITS-1:0];
    off_cnt  = off_full[COUNT_BITS-1:0];
    if (off_h[FULL_BIT]) begin
      lvl = 1'b0;
    end else if (on_h[FULL_BIT]) begin
      lvl = 1'b1;
    end else if (on_cnt == off_cnt) begin
      lvl = 1'b0;
    end else if (on_cnt < off_cnt) begin
      lvl = (count >= on_cnt) && (count < off_cnt);
    end else begin
      lvl = (count >= on_cnt) || (count < off_cnt);
    end
    return lvl;
  endfunction

endpackage

// File: rtl/multichannel_pwm_register_block.sv
// ----------------------------------------------------------------------------
// multichannel_pwm_register_block
// Byte-wide register map in front of a prescaled period counter and per-channel
// ON/OFF compares, giving one result (read byte and all channel levels) per item.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------
//  in      | in_valid / in_ready | op, reg_addr, write_byte
//  out     | out_valid/out_ready | read_byte, pwm_levels
//
// Per item, the register update and read select happen at the input transfer,
// and the channel compares run from the updated registers into the output
// register when the middle stage advances. One item can enter every cycle while
// the output is not stalled; a stalled output holds the middle stage, which in turn
// holds in_ready low. Synchronous reset restores the register map reset values.
module multichannel_pwm_register_block (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  op,
  input  logic [7:0]                  reg_addr,
  input  logic [7:0]                  write_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  read_byte,
  output logic [mpwm_pkg::LEVEL_W-1:0] pwm_levels
);
  import mpwm_pkg::*;

  logic [7:0]            mode_one, mode_one_next;
  logic [7:0]            mode_two, mode_two_next;
  logic [7:0]            prescale_value, prescale_value_next;
  logic [7:0]            tick_divider, tick_divider_next;
  logic [COUNT_BITS-1:0] period_count, period_count_next;
  ch_regs_t              chan [NUM_CHANNELS];
  ch_regs_t              chan_next [NUM_CHANNELS];

  logic                  mid_valid;
  logic [7:0]            mid_read;
  logic                  mid_advance;
  logic                  in_xfer;

  logic [7:0]            ch_off;
  logic                  ch_hit;
  logic [CH_IDX_W-1:0]   ch_sel;
  logic [1:0]            slot_sel;
  logic [1:0]            all_slot;
  logic                  all_hit;
  logic                  asleep;
  logic [7:0]            read_sel;
  logic [LEVEL_W-1:0]    levels;
  op_t                   op_cur;

  assign mid_advance = mid_valid && (!out_valid || out_ready);
  assign in_ready    = !mid_valid || mid_advance;
  assign in_xfer     = in_valid && in_ready;
  assign op_cur      = op_t'(op);

  // Address decode.
  assign ch_off   = reg_addr - ADDR_CH_BASE;
  assign ch_hit   = (reg_addr >= ADDR_CH_BASE) && ({1'b0, ch_off} < CH_BYTES);
  assign ch_sel   = ch_off[2 +: CH_IDX_W];
  assign slot_sel = ch_off[1:0];
  assign all_slot = 2'(reg_addr - ADDR_ALL_LO);
  assign all_hit  = (reg_addr >= ADDR_ALL_LO) && (reg_addr <= ADDR_ALL_HI);
  assign asleep   = mode_one[SLEEP_BIT];

  always_comb begin
    if (reg_addr == ADDR_MODE1) begin
      read_sel = mode_one;
    end else if (reg_addr == ADDR_MODE2) begin
      read_sel = mode_two;
    end else if (ch_hit) begin
      read_sel = chan[ch_sel][slot_sel];
    end else if (reg_addr == ADDR_PRESCALE) begin
      read_sel = prescale_value;
    end else begin
      read_sel = 8'd0;
    end
  end

  always_comb begin
    mode_one_next       = mode_one;
    mode_two_next       = mode_two;
    prescale_value_next = prescale_value;
    tick_divider_next   = tick_divider;
    period_count_next   = period_count;
    chan_next           = chan;
    case (op_cur)
      OP_WRITE: begin
        if (reg_addr == ADDR_MODE1) begin
          mode_one_next = write_byte;
        end else if (reg_addr == ADDR_MODE2) begin
          mode_two_next = write_byte;
        end else if (ch_hit) begin
          chan_next[ch_sel][slot_sel] = write_byte;
        end else if (all_hit) begin
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            chan_next[c][all_slot] = write_byte;
          end
        end else if (reg_addr == ADDR_PRESCALE) begin
          // The prescaler only accepts a new value while the oscillator sleeps.
          if (asleep) begin
            prescale_value_next = (write_byte < PRESCALE_MIN) ? PRESCALE_MIN : write_byte;
          end
        end
      end
      OP_TICK: begin
        if (!asleep) begin
          if (tick_divider >= prescale_value) begin
            tick_divider_next = 8'd0;
            period_count_next = period_count + COUNT_BITS'(1);
          end else begin
            tick_divider_next = tick_divider + 8'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_one       <= MODE1_RST;
      mode_two       <= MODE2_RST;
      prescale_value <= PRESCALE_RST;
      tick_divider   <= 8'd0;
      period_count   <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        chan[c][SLOT_ON_L]  <= 8'd0;
        chan[c][SLOT_ON_H]  <= 8'd0;
        chan[c][SLOT_OFF_L] <= 8'd0;
        chan[c][SLOT_OFF_H] <= OFF_H_RST;
      end
    end else if (in_xfer) begin
      mode_one       <= mode_one_next;
      mode_two       <= mode_two_next;
      prescale_value <= prescale_value_next;
      tick_divider   <= tick_divider_next;
      period_count   <= period_count_next;
      chan           <= chan_next;
    end
  end

  // Channel compares run from the registers as left by the item in the middle stage.
  always_comb begin
    levels = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      levels[c] = level_of(chan[c][SLOT_ON_L], chan[c][SLOT_ON_H],
                           chan[c][SLOT_OFF_L], chan[c][SLOT_OFF_H], period_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (in_xfer) begin
      mid_valid <= 1'b1;
    end else if (mid_advance) begin
      mid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mid_read <= (op_cur == OP_READ) ? read_sel : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mid_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_advance) begin
      read_byte  <= mid_read;
      pwm_levels <= levels;
    end
  end

endmodule
